// ===== design/dhke_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dhke_pkg
// Shared widths, operation codes and the command and status bundles of the
// key exchange core.
// ---------------------------------------------------------------------------
package dhke_pkg;

   localparam int MOD_WIDTH = 16;
   localparam int EXP_WIDTH = 16;
   localparam int CNT_WIDTH = (MOD_WIDTH > 1) ? $clog2(MOD_WIDTH) : 1;

   localparam int REQ_DATA_WIDTH = 2 * EXP_WIDTH;
   localparam int RSP_DATA_WIDTH = 3 * MOD_WIDTH;
   localparam int CSR_ADDR_WIDTH = 1;

   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_PRIME_MODULUS = 1'd0;
   localparam logic [CSR_ADDR_WIDTH-1:0] CSR_GENERATOR     = 1'd1;

   localparam logic [MOD_WIDTH-1:0] MODULUS_RESET   = MOD_WIDTH'(2);
   localparam logic [MOD_WIDTH-1:0] GENERATOR_RESET = MOD_WIDTH'(1);

   // Which exponentiation is in progress.
   typedef logic [1:0] pow_sel_type;
   localparam pow_sel_type POW_PUBLIC_A = 2'd0;
   localparam pow_sel_type POW_PUBLIC_B = 2'd1;
   localparam pow_sel_type POW_SHARED   = 2'd2;

   // Modular multiply operations; the operation also names the destination.
   typedef logic [1:0] mul_op_type;
   localparam mul_op_type MUL_REDUCE = 2'd0;  // sq     <= 1 * base mod p
   localparam mul_op_type MUL_RESULT = 2'd1;  // result <= result * sq mod p
   localparam mul_op_type MUL_SQUARE = 2'd2;  // sq     <= sq * sq mod p

   typedef struct packed {
      logic        load;
      logic        pow_init;
      logic        mul_start;
      mul_op_type  mul_op;
      logic        shift_exp;
      logic        store;
      logic        publish;
      pow_sel_type pow_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic exp_zero;
      logic exp_next_zero;
      logic exp_lsb;
   } dp_status_type;

endpackage
`default_nettype wire

// ===== design/dhke_modmul.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dhke_modmul
// Serial modular multiplier: one bit of the multiplier per cycle, doubling
// and conditional addition each reduced by a single compare and subtract.
// ---------------------------------------------------------------------------
module dhke_modmul (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           start,
   input  wire [dhke_pkg::MOD_WIDTH-1:0] x,
   input  wire [dhke_pkg::MOD_WIDTH-1:0] y,
   input  wire [dhke_pkg::MOD_WIDTH-1:0] m,
   output logic                          done,
   output logic [dhke_pkg::MOD_WIDTH-1:0] product
);
   import dhke_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [MOD_WIDTH-1:0] acc_ff, acc_in;
   logic [MOD_WIDTH-1:0] x_ff, x_in;
   logic [MOD_WIDTH-1:0] y_ff, y_in;
   logic [MOD_WIDTH-1:0] m_ff, m_in;
   logic [MOD_WIDTH-1:0] dbl;
   logic [MOD_WIDTH-1:0] sum;

   // Both operands are below m, so the sum is below 2m.
   function automatic logic [MOD_WIDTH-1:0] add_mod(input logic [MOD_WIDTH-1:0] a,
                                                    input logic [MOD_WIDTH-1:0] b,
                                                    input logic [MOD_WIDTH-1:0] md);
      logic [MOD_WIDTH-1:0] gap;
      gap = md - b;
      if (a >= gap) begin
         return a - gap;
      end
      return a + b;
   endfunction

   always_comb begin
      dbl = add_mod(acc_ff, acc_ff, m_ff);
      sum = y_ff[MOD_WIDTH-1] ? add_mod(dbl, x_ff, m_ff) : dbl;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_WIDTH'(MOD_WIDTH - 1);
         acc_in  = '0;
         x_in    = x;
         y_in    = y;
         m_in    = m;
      end else if (busy_ff) begin
         acc_in = sum;
         y_in   = {y_ff[MOD_WIDTH-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule
`default_nettype wire

// ===== design/dhke_datapath.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dhke_datapath
// Configuration registers, exponent and accumulator registers, the shared
// modular multiplier and the result register.
// ---------------------------------------------------------------------------
module dhke_datapath (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                csr_wr_en,
   input  wire [dhke_pkg::CSR_ADDR_WIDTH-1:0] csr_addr,
   input  wire [dhke_pkg::MOD_WIDTH-1:0]      csr_wdata,
   input  wire [dhke_pkg::REQ_DATA_WIDTH-1:0] req_tdata,
   input  wire dhke_pkg::dp_cmd_type          cmd,
   output dhke_pkg::dp_status_type            status,
   output logic [dhke_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata
);
   import dhke_pkg::*;

   logic [MOD_WIDTH-1:0]      modulus_ff, generator_ff;
   logic [MOD_WIDTH-1:0]      m_ff, g_ff;
   logic [EXP_WIDTH-1:0]      sec_a_ff, sec_b_ff;
   logic [EXP_WIDTH-1:0]      exp_ff;
   logic [MOD_WIDTH-1:0]      result_ff, sq_ff;
   logic [MOD_WIDTH-1:0]      pa_ff, pb_ff;
   mul_op_type                op_ff;
   logic [RSP_DATA_WIDTH-1:0] rsp_ff;

   logic [MOD_WIDTH-1:0] base;
   logic [MOD_WIDTH-1:0] mul_x, mul_y;
   logic                 mul_done;
   logic [MOD_WIDTH-1:0] mul_product;

   assign base = (cmd.pow_sel == POW_SHARED) ? pb_ff : g_ff;

   always_comb begin
      case (cmd.mul_op)
         MUL_REDUCE: begin
            mul_x = MOD_WIDTH'(1);
            mul_y = base;
         end
         MUL_RESULT: begin
            mul_x = result_ff;
            mul_y = sq_ff;
         end
         MUL_SQUARE: begin
            mul_x = sq_ff;
            mul_y = sq_ff;
         end
         default: begin
            mul_x = sq_ff;
            mul_y = sq_ff;
         end
      endcase
   end

   dhke_modmul u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .x       (mul_x),
      .y       (mul_y),
      .m       (m_ff),
      .done    (mul_done),
      .product (mul_product)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MODULUS_RESET;
         generator_ff <= GENERATOR_RESET;
      end else if (csr_wr_en) begin
         if (csr_addr == CSR_PRIME_MODULUS) begin
            modulus_ff <= csr_wdata;
         end
         if (csr_addr == CSR_GENERATOR) begin
            generator_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         sec_a_ff <= req_tdata[EXP_WIDTH-1:0];
         sec_b_ff <= req_tdata[2*EXP_WIDTH-1:EXP_WIDTH];
         m_ff     <= modulus_ff;
         g_ff     <= generator_ff;
      end
      if (cmd.mul_start) begin
         op_ff <= cmd.mul_op;
      end
      if (cmd.pow_init) begin
         exp_ff    <= (cmd.pow_sel == POW_PUBLIC_B) ? sec_b_ff : sec_a_ff;
         result_ff <= MOD_WIDTH'(1);
      end else if (cmd.shift_exp) begin
         exp_ff <= exp_ff >> 1;
      end
      if (mul_done) begin
         if (op_ff == MUL_RESULT) begin
            result_ff <= mul_product;
         end else begin
            sq_ff <= mul_product;
         end
      end
      if (cmd.store) begin
         if (cmd.pow_sel == POW_PUBLIC_A) begin
            pa_ff <= result_ff;
         end
         if (cmd.pow_sel == POW_PUBLIC_B) begin
            pb_ff <= result_ff;
         end
      end
      // The shared key is the last result; a modulus below two gives all zeros.
      if (cmd.publish) begin
         if (m_ff < MOD_WIDTH'(2)) begin
            rsp_ff <= '0;
         end else begin
            rsp_ff <= {result_ff, pb_ff, pa_ff};
         end
      end
   end

   always_comb begin
      status.mul_done      = mul_done;
      status.exp_zero      = (exp_ff == '0);
      status.exp_next_zero = ((exp_ff >> 1) == '0);
      status.exp_lsb       = exp_ff[0];
   end

   assign rsp_tdata = rsp_ff;

endmodule
`default_nettype wire

// ===== design/dhke_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// dhke_ctrl
// Sequencer for the three right-to-left square-and-multiply exponentiations
// and the handshakes on both streams.
// ---------------------------------------------------------------------------
module dhke_ctrl (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_tvalid,
   output logic                     req_tready,
   output logic                     rsp_tvalid,
   input  wire                      rsp_tready,
   output dhke_pkg::dp_cmd_type     cmd,
   input  wire dhke_pkg::dp_status_type status
);
   import dhke_pkg::*;

   localparam logic [3:0] ST_IDLE     = 4'd0;
   localparam logic [3:0] ST_POW_INIT = 4'd1;
   localparam logic [3:0] ST_WAIT_RED = 4'd2;
   localparam logic [3:0] ST_CHECK    = 4'd3;
   localparam logic [3:0] ST_WAIT_RES = 4'd4;
   localparam logic [3:0] ST_SHIFT    = 4'd5;
   localparam logic [3:0] ST_WAIT_SQ  = 4'd6;
   localparam logic [3:0] ST_STORE    = 4'd7;
   localparam logic [3:0] ST_FINISH   = 4'd8;

   logic [3:0]  state_ff, state_in;
   pow_sel_type sel_ff, sel_in;
   logic        rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      sel_in       = sel_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      cmd.pow_sel  = sel_ff;
      cmd.mul_op   = MUL_REDUCE;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               sel_in   = POW_PUBLIC_A;
               state_in = ST_POW_INIT;
            end
         end
         ST_POW_INIT: begin
            cmd.pow_init  = 1'b1;
            cmd.mul_start = 1'b1;
            cmd.mul_op    = MUL_REDUCE;
            state_in      = ST_WAIT_RED;
         end
         ST_WAIT_RED: begin
            if (status.mul_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.exp_zero) begin
               state_in = ST_STORE;
            end else if (status.exp_lsb) begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_RESULT;
               state_in      = ST_WAIT_RES;
            end else begin
               state_in = ST_SHIFT;
            end
         end
         ST_WAIT_RES: begin
            if (status.mul_done) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            cmd.shift_exp = 1'b1;
            if (status.exp_next_zero) begin
               state_in = ST_STORE;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_op    = MUL_SQUARE;
               state_in      = ST_WAIT_SQ;
            end
         end
         ST_WAIT_SQ: begin
            if (status.mul_done) begin
               state_in = ST_CHECK;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            if (sel_ff == POW_SHARED) begin
               state_in = ST_FINISH;
            end else begin
               sel_in   = sel_ff + 1'b1;
               state_in = ST_POW_INIT;
            end
         end
         ST_FINISH: begin
            // The result register is loaded once the previous item has left it.
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.publish  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= POW_PUBLIC_A;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

endmodule
`default_nettype wire

// ===== design/diffie_hellman_key_exchange_core.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// diffie_hellman_key_exchange_core
// Computes both public values and the shared key of a key exchange.
// ---------------------------------------------------------------------------
// Each item carries two private exponents. With the configured modulus p and
// generator g the core returns g^secret_a mod p, g^secret_b mod p and
// public_b^secret_a mod p; a modulus below two gives all-zero results. The
// three exponentiations run one after another through a single serial modular
// multiplier that handles one multiplier bit per cycle. An exponentiation costs
// one base reduction plus, for every exponent bit up to the highest set one, an
// optional multiply and, except after the last bit, a square; with an all-ones
// exponent that is 32 multiplies. The result of an item is therefore offered
// far sooner for small exponents than for large ones, and the next item can be
// accepted in the same cycle that the result is offered. One item is worked on
// at a time; the next is taken while a finished result still waits on the
// result stream, and it stalls before its own result only if that earlier
// result has still not left. Configuration writes take effect for the next item.
module diffie_hellman_key_exchange_core (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 csr_wr_en,
   input  wire [dhke_pkg::CSR_ADDR_WIDTH-1:0]  csr_addr,
   input  wire [dhke_pkg::MOD_WIDTH-1:0]       csr_wdata,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   input  wire [dhke_pkg::REQ_DATA_WIDTH-1:0]  req_tdata,   // secret_a, secret_b
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   output logic [dhke_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata    // public_a, public_b, shared_key
);
   import dhke_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   dhke_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .status     (status)
   );

   dhke_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .req_tdata (req_tdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule
`default_nettype wire
